// ===== src/dp2p_pkg.sv =====
package dp2p_pkg;

  // Field widths of the pixel, point and register data.
  localparam int DEPTH_W = 16;
  localparam int IDX_W   = 11;
  localparam int CTR_W   = 16;
  localparam int RECIP_W = 24;
  localparam int COORD_W = 24;

  // Number of register stages from an accepted pixel to the output register.
  localparam int STAGES = 4;

  // Fraction bits of depth * (Q.4 offset) * (Q0.24 reciprocal).
  localparam int FRAC_BITS = 28;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X_RECIP = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y_RECIP = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 4'd3;

  // Register reset values.
  localparam logic [RECIP_W-1:0] RECIP_RESET  = 24'd16777;
  localparam logic [CTR_W-1:0]   CENTER_RESET = 16'd0;

  typedef logic [DEPTH_W-1:0]        depth_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CTR_W-1:0]          ctr_t;
  typedef logic [RECIP_W-1:0]        recip_t;
  typedef logic signed [COORD_W-1:0] coord_t;

endpackage

// ===== src/dp2p_axis.sv =====
module dp2p_axis
  import dp2p_pkg::*;
(
  input  logic   clk,
  input  logic   en,
  input  idx_t   idx,
  input  ctr_t   ctr,
  input  depth_t depth,
  input  recip_t recip,
  output coord_t coord
);

  localparam int DIFF_W  = CTR_W + 1;
  localparam int PROD1_W = CTR_W + DEPTH_W;
  localparam int PROD2_W = PROD1_W + RECIP_W;
  localparam int RND_W   = PROD2_W - FRAC_BITS + 1;
  localparam logic [RND_W-1:0] POS_LIM = RND_W'((1 << (COORD_W - 1)) - 1);
  localparam logic [RND_W-1:0] NEG_LIM = RND_W'(1 << (COORD_W - 1));

  logic [DIFF_W-1:0]  diff;
  logic [CTR_W-1:0]   mag;
  logic [RND_W-1:0]   rnd;
  coord_t             coord_nxt;

  logic [CTR_W-1:0]   mag_r;
  logic               neg1_r;
  depth_t             depth_r;
  logic [PROD1_W-1:0] prod1_r;
  logic               neg2_r;
  logic [PROD2_W-1:0] prod2_r;
  logic               neg3_r;
  coord_t             coord_r;

  // Stage 1: signed offset of the pixel from the principal point, in 1/16 pixel.
  always_comb begin
    diff = DIFF_W'({idx, 4'b0000}) - DIFF_W'(ctr);
    mag  = diff[DIFF_W-1] ? CTR_W'(-diff) : diff[CTR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag;
      neg1_r  <= diff[DIFF_W-1];
      depth_r <= depth;
    end
  end

  // Stage 2: offset magnitude times depth.
  always_ff @(posedge clk) begin
    if (en) begin
      prod1_r <= PROD1_W'(mag_r) * PROD1_W'(depth_r);
      neg2_r  <= neg1_r;
    end
  end

  // Stage 3: times the focal reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      prod2_r <= PROD2_W'(prod1_r) * PROD2_W'(recip);
      neg3_r  <= neg2_r;
    end
  end

  // Stage 4: round half away from zero, saturate, then apply the sign.
  always_comb begin
    rnd = RND_W'(prod2_r[PROD2_W-1:FRAC_BITS]) + RND_W'(prod2_r[FRAC_BITS-1]);
    if (neg3_r) begin
      if (rnd > NEG_LIM) begin
        rnd = NEG_LIM;
      end
      coord_nxt = coord_t'(-rnd);
    end else begin
      if (rnd > POS_LIM) begin
        rnd = POS_LIM;
      end
      coord_nxt = coord_t'(rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coord_r <= coord_nxt;
    end
  end

  assign coord = coord_r;

endmodule

// ===== src/depth_pixel_to_point_unit.sv =====
// A pixel accepted by the unit passes through four register stages (offset,
// multiply by depth, multiply by focal reciprocal, round and saturate) and
// shows as a result in the output register until it transfers on out_ready.
// The unit takes one pixel per cycle unless stalled; all stages advance together.
// When a result waits at the output, every stage holds and in_ready drops.
// Reset empties the pipeline and loads the focal and principal point registers.
module depth_pixel_to_point_unit
  import dp2p_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  depth_t                in_depth_mm,
  input  idx_t                  in_col,
  input  idx_t                  in_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_point_valid,
  output coord_t                out_x_mm,
  output coord_t                out_y_mm,
  output depth_t                out_z_mm,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  recip_t focal_x_recip_r;
  recip_t focal_y_recip_r;
  ctr_t   center_x_r;
  ctr_t   center_y_r;

  logic   en;
  logic   in_frame;
  logic   ok_in;
  coord_t x_raw;
  coord_t y_raw;

  logic [STAGES-1:0] valid_r;
  logic [STAGES-1:0] ok_r;
  depth_t            z_r [STAGES];

  // Configuration registers; every transfer is taken at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_recip_r <= RECIP_RESET;
      focal_y_recip_r <= RECIP_RESET;
      center_x_r      <= CENTER_RESET;
      center_y_r      <= CENTER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FOCAL_X_RECIP: focal_x_recip_r <= cfg_data[RECIP_W-1:0];
        REG_FOCAL_Y_RECIP: focal_y_recip_r <= cfg_data[RECIP_W-1:0];
        REG_CENTER_X:      center_x_r      <= cfg_data[CTR_W-1:0];
        REG_CENTER_Y:      center_y_r      <= cfg_data[CTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is waiting.
  assign en       = !valid_r[STAGES-1] || out_ready;
  assign in_ready = en;

  // A point is defined only for a measured depth inside the frame.
  assign in_frame = (32'(in_col) < 32'(MAX_WIDTH)) && (32'(in_row) < 32'(MAX_HEIGHT));
  assign ok_in    = (in_depth_mm != '0) && in_frame;

  // Valid bits and pass-through fields travel alongside the axis datapaths.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok_r <= {ok_r[STAGES-2:0], ok_in};
      z_r[0] <= in_depth_mm;
      for (int i = 1; i < STAGES; i++) begin
        z_r[i] <= z_r[i-1];
      end
    end
  end

  // One datapath per lateral axis.
  dp2p_axis u_axis_x (
    .clk   (clk),
    .en    (en),
    .idx   (in_col),
    .ctr   (center_x_r),
    .depth (in_depth_mm),
    .recip (focal_x_recip_r),
    .coord (x_raw)
  );

  dp2p_axis u_axis_y (
    .clk   (clk),
    .en    (en),
    .idx   (in_row),
    .ctr   (center_y_r),
    .depth (in_depth_mm),
    .recip (focal_y_recip_r),
    .coord (y_raw)
  );

  // Undefined points read as all-zero coordinates.
  assign out_valid       = valid_r[STAGES-1];
  assign out_point_valid = ok_r[STAGES-1];
  assign out_x_mm        = ok_r[STAGES-1] ? x_raw : '0;
  assign out_y_mm        = ok_r[STAGES-1] ? y_raw : '0;
  assign out_z_mm        = ok_r[STAGES-1] ? z_r[STAGES-1] : '0;

endmodule
